// File: rtl/maa_pkg.sv
// Shared types and constants for the annealing acceptor.
// Used by the controller, the datapath and the top level.
package maa_pkg;

  localparam int unsigned DIV_STEPS   = 21;
  localparam int unsigned CNT_W       = 5;
  localparam int unsigned EXP_MAX     = 10;

  localparam logic [31:0] INV_KB_Q16  = 32'd760513700;
  localparam logic [31:0] LOG2E_Q31   = 32'd3098164010;
  localparam logic [20:0] X_CAP_Q16   = 21'd1507328;

  localparam logic [31:0] INIT_TEMP_RST = 32'd19660800;
  localparam logic [31:0] COOL_RST      = 32'hFFFF_FFFF;
  localparam logic [31:0] MAX_STEPS_RST = 32'd1000000;

  localparam logic [1:0] REG_INIT_TEMP = 2'd0;
  localparam logic [1:0] REG_COOLING   = 2'd1;
  localparam logic [1:0] REG_MAX_STEPS = 2'd2;

  // 2^(-2^-i) in Q0.32, i = 1..10
  localparam logic [31:0] POW2_NEG_FRAC [EXP_MAX] = '{
    32'd3037000500, 32'd3611622603, 32'd3938502376, 32'd4112874773,
    32'd4202935003, 32'd4248701965, 32'd4271771996, 32'd4283353945,
    32'd4289156690, 32'd4292060984
  };

  typedef enum logic [2:0] {
    MUL_T,
    MUL_N,
    MUL_Y,
    MUL_P,
    MUL_S
  } mul_sel_t;

  typedef struct packed {
    mul_sel_t mul_sel;
    logic     in_ready;
    logic     take_in;
    logic     ld_temp;
    logic     div_start;
    logic     div_step;
    logic     exp_start;
    logic     exp_skip;
    logic     exp_const;
    logic     exp_take;
    logic     decide;
    logic     energy;
    logic     scale;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic past_end;
    logic de_neg;
    logic temp_zero;
    logic x_over;
    logic div_done;
    logic exp_done;
    logic exp_bit;
    logic p_full;
    logic out_free;
  } stat_t;

endpackage

// File: rtl/maa_if.sv
// Channel interfaces: input items, result items and configuration writes.
// Does not depend on maa_pkg; the register index is two bits wide, as the REG_ constants there.
interface maa_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] energy_change;
  logic        [31:0] random_value;
  modport source (output valid, output energy_change, output random_value, input ready);
  modport sink   (input valid, input energy_change, input random_value, output ready);
endinterface

interface maa_out_if;
  logic               valid;
  logic               ready;
  logic               accepted;
  logic signed [47:0] total_energy;
  logic        [31:0] temperature_now;
  logic        [31:0] step_index;
  logic               past_end;
  modport source (output valid, output accepted, output total_energy,
                  output temperature_now, output step_index, output past_end,
                  input ready);
  modport sink   (input valid, input accepted, input total_energy,
                  input temperature_now, input step_index, input past_end,
                  output ready);
endinterface

interface maa_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/maa_ctrl.sv
// Sequencer for one item: temperature, divide, exp steps, decision, update.
// Depends on maa_pkg for the command and status structs.
module maa_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  maa_pkg::stat_t st,
  output maa_pkg::cmd_t  cmd
);
  import maa_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_TEMP   = 12'b0000_0000_0010,
    S_DIVI   = 12'b0000_0000_0100,
    S_DIV    = 12'b0000_0000_1000,
    S_MULY   = 12'b0000_0001_0000,
    S_EXPN   = 12'b0000_0010_0000,
    S_EXP    = 12'b0000_0100_0000,
    S_EXPT   = 12'b0000_1000_0000,
    S_DECIDE = 12'b0001_0000_0000,
    S_ENERGY = 12'b0010_0000_0000,
    S_SCALE  = 12'b0100_0000_0000,
    S_DONE   = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.mul_sel = MUL_T;
    unique case (state_r)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.mul_sel  = MUL_T;
        if (st.in_valid) begin
          cmd.take_in = 1'b1;
          state_nxt   = st.past_end ? S_DONE : S_TEMP;
        end
      end
      S_TEMP: begin
        cmd.ld_temp = 1'b1;
        cmd.mul_sel = MUL_N;
        state_nxt   = S_DIVI;
      end
      S_DIVI: begin
        if (st.de_neg || st.temp_zero) begin
          state_nxt = S_DECIDE;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = st.x_over ? S_MULY : S_DIV;
        end
      end
      S_DIV: begin
        if (st.div_done) begin
          state_nxt = S_MULY;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_MULY: begin
        cmd.mul_sel = MUL_Y;
        state_nxt   = S_EXPN;
      end
      S_EXPN: begin
        cmd.exp_start = 1'b1;
        state_nxt     = S_EXP;
      end
      S_EXP: begin
        priority if (st.exp_done) begin
          state_nxt = S_DECIDE;
        end else if (!st.exp_bit) begin
          cmd.exp_skip = 1'b1;
        end else if (st.p_full) begin
          cmd.exp_const = 1'b1;
        end else begin
          cmd.mul_sel = MUL_P;
          state_nxt   = S_EXPT;
        end
      end
      S_EXPT: begin
        cmd.exp_take = 1'b1;
        state_nxt    = S_EXP;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = S_ENERGY;
      end
      S_ENERGY: begin
        cmd.energy  = 1'b1;
        cmd.mul_sel = MUL_S;
        state_nxt   = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/maa_dp.sv
// Datapath: config registers, shared 32x32 multiplier, restoring divider,
// exp step registers, energy total and output register. Depends on maa_pkg, maa_if.
module maa_dp #(
  parameter int unsigned EXP_TABLE_BITS = 6
) (
  input  logic           clk,
  input  logic           rst_n,
  maa_cfg_if.sink        cfg_s,
  maa_in_if.sink         in_s,
  maa_out_if.source      out_s,
  input  maa_pkg::cmd_t  cmd,
  output maa_pkg::stat_t st
);
  import maa_pkg::*;

  localparam logic [CNT_W-1:0] EXP_LAST = CNT_W'(EXP_TABLE_BITS);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS);

  logic [31:0] init_temp_r, cool_r, max_steps_r;
  logic [32:0] scale_r;
  logic signed [47:0] total_r;
  logic [31:0] step_cnt_r;

  logic signed [31:0] de_r;
  logic [31:0] rnd_r, step_idx_r, temp_r, rem_r;
  logic        past_r, acc_r;
  logic [20:0] nlo_r, q_r;
  logic [CNT_W-1:0] cnt_r;
  logic [32:0] p_r;
  logic [4:0]  n_r;
  logic [15:0] frac_r;
  logic [63:0] prod_r;

  logic        out_valid_r, out_acc_r, out_past_r;
  logic signed [47:0] out_total_r;
  logic [31:0] out_temp_r, out_step_r;

  logic [31:0] mul_a, mul_b;
  logic [20:0] x_cap;
  logic [32:0] rem2;
  logic        div_ge;
  logic [32:0] rem_sub;
  logic [21:0] y_val;
  logic signed [48:0] sum;
  logic signed [47:0] sum_sat;
  logic [32:0] p_shift;

  assign cfg_s.ready = 1'b1;
  assign in_s.ready  = cmd.in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_temp_r <= INIT_TEMP_RST;
      cool_r      <= COOL_RST;
      max_steps_r <= MAX_STEPS_RST;
    end else if (cfg_s.valid) begin
      unique case (cfg_s.index)
        REG_INIT_TEMP: init_temp_r <= cfg_s.data;
        REG_COOLING:   cool_r      <= cfg_s.data;
        REG_MAX_STEPS: max_steps_r <= cfg_s.data;
        default: ;
      endcase
    end
  end

  assign x_cap = (q_r > X_CAP_Q16) ? X_CAP_Q16 : q_r;

  always_comb begin
    unique case (cmd.mul_sel)
      MUL_T:   begin mul_a = init_temp_r;        mul_b = scale_r[31:0]; end
      MUL_N:   begin mul_a = de_r;               mul_b = INV_KB_Q16;    end
      MUL_Y:   begin mul_a = {11'b0, x_cap};     mul_b = LOG2E_Q31;     end
      MUL_P:   begin mul_a = p_r[31:0];
                     mul_b = POW2_NEG_FRAC[cnt_r[3:0]]; end
      MUL_S:   begin mul_a = scale_r[31:0];      mul_b = cool_r;        end
      default: begin mul_a = '0;                 mul_b = '0;            end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= 64'(mul_a) * 64'(mul_b);
  end

  assign rem2    = {rem_r, nlo_r[20]};
  assign div_ge  = rem2 >= {1'b0, temp_r};
  assign rem_sub = rem2 - {1'b0, temp_r};
  assign y_val   = prod_r[52:31];
  assign p_shift = p_r >> n_r;
  assign sum     = {total_r[47], total_r} + 49'(de_r);

  always_comb begin
    if (sum[48] != sum[47]) begin
      sum_sat = sum[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
    end else begin
      sum_sat = sum[47:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r    <= {1'b1, 32'b0};
      total_r    <= '0;
      step_cnt_r <= '0;
    end else begin
      if (cmd.energy && acc_r) begin
        total_r <= sum_sat;
      end
      if (cmd.scale) begin
        scale_r    <= scale_r[32] ? {1'b0, cool_r} : {1'b0, prod_r[63:32]};
        step_cnt_r <= step_cnt_r + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      de_r       <= in_s.energy_change;
      rnd_r      <= in_s.random_value;
      step_idx_r <= step_cnt_r;
      past_r     <= step_cnt_r > max_steps_r;
      acc_r      <= 1'b0;
    end
    if (cmd.ld_temp) begin
      temp_r <= scale_r[32] ? init_temp_r : prod_r[63:32];
    end
    if (cmd.div_start) begin
      cnt_r <= '0;
      nlo_r <= prod_r[20:0];
      rem_r <= prod_r[52:21];
      q_r   <= st.x_over ? X_CAP_Q16 : '0;
    end
    if (cmd.div_step) begin
      rem_r <= div_ge ? rem_sub[31:0] : rem2[31:0];
      nlo_r <= {nlo_r[19:0], 1'b0};
      q_r   <= {q_r[19:0], div_ge};
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.exp_start) begin
      cnt_r  <= '0;
      n_r    <= y_val[20:16];
      frac_r <= y_val[15:0];
      p_r    <= (y_val[21:16] >= 6'd32) ? 33'd0 : {1'b1, 32'b0};
    end
    if (cmd.exp_skip || cmd.exp_const || cmd.exp_take) begin
      frac_r <= {frac_r[14:0], 1'b0};
      cnt_r  <= cnt_r + 1'b1;
    end
    if (cmd.exp_const) begin
      p_r <= {1'b0, POW2_NEG_FRAC[cnt_r[3:0]]};
    end
    if (cmd.exp_take) begin
      p_r <= {1'b0, prod_r[63:32]};
    end
    if (cmd.decide) begin
      priority if (de_r[31]) begin
        acc_r <= 1'b1;
      end else if (temp_r == 32'd0) begin
        acc_r <= 1'b0;
      end else begin
        acc_r <= {1'b0, rnd_r} < p_shift;
      end
    end
  end

  assign st.in_valid  = in_s.valid;
  assign st.past_end  = step_cnt_r > max_steps_r;
  assign st.de_neg    = de_r[31];
  assign st.temp_zero = temp_r == 32'd0;
  assign st.x_over    = prod_r[63:21] >= {11'b0, temp_r};
  assign st.div_done  = cnt_r == DIV_LAST;
  assign st.exp_done  = cnt_r == EXP_LAST;
  assign st.exp_bit   = frac_r[15];
  assign st.p_full    = p_r[32];
  assign st.out_free  = !out_valid_r || out_s.ready;

  // hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_s.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_acc_r   <= acc_r && !past_r;
      out_total_r <= total_r;
      out_temp_r  <= past_r ? 32'd0 : temp_r;
      out_step_r  <= step_idx_r;
      out_past_r  <= past_r;
    end
  end

  assign out_s.valid           = out_valid_r;
  assign out_s.accepted        = out_acc_r;
  assign out_s.total_energy    = out_total_r;
  assign out_s.temperature_now = out_temp_r;
  assign out_s.step_index      = out_step_r;
  assign out_s.past_end        = out_past_r;

`ifndef SYNTH
  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> cnt_r < DIV_LAST)
    else $error("divider stepped past its last quotient bit");
  a_scale_max: assert property (@(posedge clk) disable iff (!rst_n)
    scale_r[32] |-> scale_r[31:0] == 32'd0)
    else $error("cooling scale above one");
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("loaded result not presented");
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_s.ready))
    else $error("result register overwritten while held");
`endif

endmodule

// File: rtl/metropolis_annealing_acceptor_core.sv
// Channel    | Dir | Payload
// in_s       | in  | energy_change (s32 Q16.16), random_value (u32 Q0.32)
// out_s      | out | accepted, total_energy (s48), temperature_now, step_index, past_end
// cfg_s      | in  | index (2), data (32); always ready
// One item at a time; its time is set by the 21-step restoring divider
// for the Boltzmann exponent and by the exp table bits on the shared
// multiplier. The cap on the exponent skips the divider; a negative change or
// zero temperature skips divider and exp steps; a past-end item goes straight out.
// Synchronous active-low reset; no clearing pass. A stalled output holds its
// result while the next item is already accepted and worked on.
module metropolis_annealing_acceptor_core #(
  parameter int unsigned EXP_TABLE_BITS = 6
) (
  input  logic       clk,
  input  logic       rst_n,
  maa_cfg_if.sink    cfg_s,
  maa_in_if.sink     in_s,
  maa_out_if.source  out_s
);
  import maa_pkg::*;

  cmd_t  cmd;
  stat_t st;

  maa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .cmd   (cmd)
  );

  maa_dp #(
    .EXP_TABLE_BITS (EXP_TABLE_BITS)
  ) u_dp (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg_s (cfg_s),
    .in_s  (in_s),
    .out_s (out_s),
    .cmd   (cmd),
    .st    (st)
  );

endmodule

// File: tb/metropolis_annealing_acceptor_core_test.sv
// Self-checking bench for the Metropolis acceptance core with geometric cooling.
// Depends on maa_pkg and the channel interfaces in maa_if; predicts every result
// in a scoreboard class and drives the channels with random idling on both sides.
module metropolis_annealing_acceptor_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import maa_pkg::*;

  localparam logic [1:0] REG_NONE = 2'd3;
  localparam int unsigned TABLE_BITS = 6;
  localparam longint unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned SETTLE_CYCLES = 60;

  typedef struct {
    logic               accepted;
    logic signed [47:0] total_energy;
    logic        [31:0] temperature_now;
    logic        [31:0] step_index;
    logic               past_end;
  } move_result_t;

  class anneal_scoreboard;
    logic [31:0] init_temp = INIT_TEMP_RST;
    logic [31:0] cool = COOL_RST;
    logic [31:0] last_step = MAX_STEPS_RST;
    logic [32:0] scale = 33'h1_0000_0000;
    logic signed [47:0] total = '0;
    logic [31:0] step = '0;
    move_result_t pending_q[$];
    int errors = 0;

    function void write_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_INIT_TEMP: init_temp = val;
        REG_COOLING:   cool = val;
        REG_MAX_STEPS: last_step = val;
        default: ;
      endcase
    endfunction

    // exp(-x) for x in Q16.16, Q0.32 result in [0, 2^32]
    function logic [32:0] neg_exp(logic [63:0] x);
      logic [63:0] y;
      logic [63:0] n;
      logic [64:0] p;
      if (x > 64'(X_CAP_Q16)) x = 64'(X_CAP_Q16);
      y = (x * 64'(LOG2E_Q31)) >> 31;
      n = y >> 16;
      if (n >= 32) return '0;
      p = 65'h1_0000_0000;
      for (int i = 1; i <= TABLE_BITS; i++) begin
        if (y[16 - i]) p = (p * 65'(POW2_NEG_FRAC[i - 1])) >> 32;
      end
      return 33'(p >> n);
    endfunction

    function void note_move(logic signed [31:0] de, logic [31:0] rnd);
      move_result_t r;
      logic [64:0] t_wide;
      logic [31:0] temp;
      logic [63:0] x;
      logic signed [48:0] sum;
      r.step_index = step;
      if (step > last_step) begin
        r.accepted = 0;
        r.total_energy = total;
        r.temperature_now = '0;
        r.past_end = 1;
        pending_q.push_back(r);
        return;
      end
      t_wide = (65'(init_temp) * 65'(scale)) >> 32;
      temp = t_wide[31:0];
      if (de < 0) r.accepted = 1;
      else if (temp == 0) r.accepted = 0;
      else begin
        x = (64'(de) * 64'(INV_KB_Q16)) / 64'(temp);
        r.accepted = 33'(rnd) < neg_exp(x);
      end
      if (r.accepted) begin
        sum = 49'(total) + 49'(de);
        if (sum > 49'sh0_7FFF_FFFF_FFFF) sum = 49'sh0_7FFF_FFFF_FFFF;
        if (sum < -49'sh0_8000_0000_0000) sum = -49'sh0_8000_0000_0000;
        total = sum[47:0];
      end
      r.total_energy = total;
      r.temperature_now = temp;
      r.past_end = 0;
      pending_q.push_back(r);
      t_wide = (65'(scale) * 65'(cool)) >> 32;
      scale = t_wide[32:0];
      step = step + 1;
    endfunction

    function void check_result(move_result_t got);
      move_result_t want;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result, step %0d", $time, got.step_index);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got.accepted !== want.accepted) begin
        $display("%0t: accepted expected %0b actual %0b", $time, want.accepted, got.accepted);
        errors++;
      end
      if (got.total_energy !== want.total_energy) begin
        $display("%0t: total_energy expected %0d actual %0d", $time,
                 want.total_energy, got.total_energy);
        errors++;
      end
      if (got.temperature_now !== want.temperature_now) begin
        $display("%0t: temperature_now expected %0d actual %0d", $time,
                 want.temperature_now, got.temperature_now);
        errors++;
      end
      if (got.step_index !== want.step_index) begin
        $display("%0t: step_index expected %0d actual %0d", $time,
                 want.step_index, got.step_index);
        errors++;
      end
      if (got.past_end !== want.past_end) begin
        $display("%0t: past_end expected %0b actual %0b", $time, want.past_end, got.past_end);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic calm = 0;
  longint unsigned cycles = 0;
  anneal_scoreboard moves = new();

  maa_cfg_if cfg_ch();
  maa_in_if  in_ch();
  maa_out_if out_ch();

  metropolis_annealing_acceptor_core #(.EXP_TABLE_BITS(TABLE_BITS)) DUT (
    .clk(clk), .rst_n(rst_n), .cfg_s(cfg_ch), .in_s(in_ch), .out_s(out_ch)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    cfg_ch.valid = 0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    in_ch.valid = 0;
    in_ch.energy_change = '0;
    in_ch.random_value = '0;
    out_ch.ready = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ch.ready <= calm || ($urandom_range(0, 99) >= 37);
  end

  always @(posedge clk) begin
    move_result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.accepted = out_ch.accepted;
      got.total_energy = out_ch.total_energy;
      got.temperature_now = out_ch.temperature_now;
      got.step_index = out_ch.step_index;
      got.past_end = out_ch.past_end;
      moves.check_result(got);
    end
  end

  // Leaves valid high after the handshake; lower it only before an idle gap.
  task automatic send_move(logic signed [31:0] de, logic [31:0] rnd);
    if (!calm && $urandom_range(0, 99) < 37) begin
      in_ch.valid <= 0;
      do @(posedge clk); while (!calm && $urandom_range(0, 99) < 37);
    end
    in_ch.valid <= 1;
    in_ch.energy_change <= de;
    in_ch.random_value <= rnd;
    do @(posedge clk); while (!in_ch.ready);
    moves.note_move(de, rnd);
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    @(posedge clk);
    while (moves.pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_ch.valid <= 1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    moves.write_reg(idx, val);
    cfg_ch.valid <= 0;
    @(posedge clk);
  endtask

  task automatic random_move();
    logic signed [31:0] de;
    logic [31:0] rnd;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: de = $urandom_range(0, 20000);
      4:          de = $urandom_range(0, 400000);
      5, 6:       de = -$signed({1'b0, 31'($urandom_range(1, 400000))});
      7, 8:       de = $urandom;
      default:    de = '0;
    endcase
    case ($urandom_range(0, 9))
      0:       rnd = '0;
      1:       rnd = '1;
      default: rnd = $urandom;
    endcase
    send_move(de, rnd);
  endtask

  initial begin
    logic [31:0] temps [4];
    int n;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // boundary energy changes and random values at the default temperature
    send_move(32'sd0, '1);
    send_move(-32'sd1, '1);
    send_move(32'sh8000_0000, '0);
    send_move(32'sh7FFF_FFFF, '0);
    send_move(32'sd1, '0);
    send_move(32'sd1, '1);
    send_move(32'sd2000, '0);
    send_move(32'sd2000, 32'h8000_0000);
    send_move(32'sd2000, '1);
    send_move(32'sd5000, 32'h1000_0000);
    send_move(32'sh0000_FFFF, 32'h0000_0001);
    drain();

    // zero temperature rejects every non-negative change
    write_reg(REG_INIT_TEMP, '0);
    send_move(32'sd0, '0);
    send_move(32'sd100, '0);
    send_move(-32'sd100, '1);
    drain();
    write_reg(REG_NONE, 32'h1234_5678);
    write_reg(REG_INIT_TEMP, '1);
    write_reg(REG_MAX_STEPS, moves.step + 2);
    for (int i = 0; i < 5; i++) send_move(32'sd3000, $urandom);
    drain();

    temps = '{INIT_TEMP_RST, 32'd655360, '1, 32'd1};
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_INIT_TEMP, ph < 4 ? temps[ph] : $urandom);
      write_reg(REG_COOLING, ph == 0 ? '1 : 32'hFFFF_FFFF - $urandom_range(0, 1 << 24));
      write_reg(REG_MAX_STEPS, ph == 7 ? '1 : moves.step + $urandom_range(150, 260));
      calm = (ph == 3);
      n = $urandom_range(200, 260);
      for (int i = 0; i < n; i++) random_move();
      drain();
    end
    calm = 0;

    // collapse the scale to zero, then stop all steps
    write_reg(REG_COOLING, '0);
    write_reg(REG_INIT_TEMP, '1);
    for (int i = 0; i < 20; i++) random_move();
    drain();
    write_reg(REG_MAX_STEPS, '0);
    for (int i = 0; i < 20; i++) random_move();
    drain();

    if (moves.errors == 0 && moves.pending_q.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
